// ===== sv/bfm_pkg.sv =====
// Shared constants and state encoding for the buddy free-merge tracker.
package bfm_pkg;

  localparam int ORDERS_DEF = 12;
  localparam int ORDER_W    = 4;
  localparam int ADDR_W     = 12;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOK   = 5'b00100,
    S_CHECK  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

endpackage

// ===== sv/bfm_map_ram.sv =====
// One-bit-wide free map memory, one write port, one registered read port.
module bfm_map_ram #(
  parameter int IDX_W = bfm_pkg::ORDERS_DEF + 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic             wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic             rd_data
);

  localparam int DEPTH = 1 << IDX_W;

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ===== sv/buddy_free_merge_top.sv =====
// Top level of the buddy-system free-block tracker with buddy merging.
//
// Each input beat names a block (order, address); func 0 marks it free, func 1
// releases it and merges it with free buddies order by order. One result beat
// per input gives the block finally marked free, or flags a misaligned or
// oversized request and echoes it. The free bits of all orders sit in one
// 2^(ORDERS+1) x 1 memory with a registered read; every merge step is one read
// of the buddy's bit. A result held by out_stall keeps the finish state until
// out_stall drops. After reset a clearing pass writes every entry to zero,
// during which in_stall stays high. A result may wait on out_stall while the
// next beat is already accepted and worked on.
module buddy_free_merge_top #(
  parameter int ORDERS = bfm_pkg::ORDERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic [bfm_pkg::ORDER_W-1:0]  block_order,
  input  logic [bfm_pkg::ADDR_W-1:0]   block_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bfm_pkg::ORDER_W-1:0]  merged_order,
  output logic [bfm_pkg::ADDR_W-1:0]   merged_address,
  output logic                         misaligned
);

  import bfm_pkg::*;

  localparam int AW    = ORDERS;
  localparam int IDX_W = ORDERS + 1;
  localparam int KW    = $clog2(ORDERS + 1);

  state_t             state;
  logic               func_r;
  logic               mis_r;
  logic [ORDER_W-1:0] ord_in_r;
  logic [KW-1:0]      k_r;
  logic [AW-1:0]      addr_r;
  logic [IDX_W-1:0]   bud_idx_r;
  logic [IDX_W-1:0]   clr_idx;

  logic               in_acc;
  logic               out_free;
  logic [AW-1:0]      addr_in;
  logic [AW-1:0]      low_mask;
  logic               refused;

  logic [KW-1:0]      k_up;
  logic [AW-1:0]      addr_up;
  logic [KW-1:0]      look_k;
  logic [AW-1:0]      look_addr;
  logic [AW-1:0]      look_bit;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_en;
  logic               rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_data;
  logic               merge;

  // Order k occupies entries from 2^(ORDERS+1) - 2^(ORDERS+1-k) on.
  function automatic logic [IDX_W-1:0] map_idx(input logic [KW-1:0] k,
                                               input logic [AW-1:0] a);
    logic [IDX_W:0]  full;
    logic [IDX_W:0]  base;
    logic [AW-1:0]   blk;
    full = {1'b1, {IDX_W{1'b0}}};
    base = full - (full >> k);
    blk  = a >> k;
    return base[IDX_W-1:0] + IDX_W'(blk);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign addr_in  = AW'(block_address);

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      low_mask[i] = (i < int'(block_order));
    end
  end

  assign refused = (int'(block_order) > ORDERS) || ((addr_in & low_mask) != '0);

  // Merge outcome of the current check; the next read follows it directly.
  assign merge   = (state == S_CHECK) && rd_data;
  assign k_up    = k_r + KW'(1);
  assign addr_up = addr_r & ~(AW'(1) << k_r);

  always_comb begin
    if (merge) begin
      look_k    = k_up;
      look_addr = addr_up;
    end else begin
      look_k    = k_r;
      look_addr = addr_r;
    end
    look_bit = AW'(1) << look_k;
    rd_idx   = map_idx(look_k, look_addr ^ look_bit);
  end

  always_comb begin
    rd_en = 1'b0;
    unique case (state)
      S_LOOK:  rd_en = !mis_r && func_r && (int'(k_r) != ORDERS);
      S_CHECK: rd_en = merge && (int'(k_up) != ORDERS);
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = bud_idx_r;
    wr_data = 1'b0;
    unique case (state)
      S_CLEAR: begin
        wr_en  = 1'b1;
        wr_idx = clr_idx;
      end
      S_CHECK: begin
        wr_en  = merge;
        wr_idx = bud_idx_r;
      end
      S_FINISH: begin
        wr_en   = out_free && !mis_r;
        wr_idx  = map_idx(k_r, addr_r);
        wr_data = 1'b1;
      end
      default: wr_en = 1'b0;
    endcase
  end

  bfm_map_ram #(
    .IDX_W (IDX_W)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == {IDX_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (rd_en) begin
            state <= S_CHECK;
          end else begin
            state <= S_FINISH;
          end
        end
        S_CHECK: begin
          if (!rd_en) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= func;
      mis_r    <= refused;
      ord_in_r <= block_order;
      k_r      <= KW'(block_order);
      addr_r   <= addr_in;
    end else if (merge) begin
      k_r    <= k_up;
      addr_r <= addr_up;
    end
    if (rd_en) begin
      bud_idx_r <= rd_idx;
    end
    if (state == S_FINISH && out_free) begin
      merged_order   <= mis_r ? ord_in_r : ORDER_W'(k_r);
      merged_address <= ADDR_W'(addr_r);
      misaligned     <= mis_r;
    end
  end

  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_LOOK)
    else $error("accepted beat did not start a lookup");

  a_check_below_top: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> int'(k_r) < ORDERS)
    else $error("buddy check at or above top order");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !wr_en)
    else $error("free map written while idle");

  a_refused_no_read: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK && mis_r |-> !rd_en && $past(in_valid && !in_stall))
    else $error("refused request touched the free map");

  a_result_order_range: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !misaligned |-> int'(merged_order) <= ORDERS)
    else $error("merged order above top order");

endmodule
